// ----- src/bvst_pkg.sv -----
// ---------------------------------------------------------------------------
// bvst_pkg: shared types and constants for the bit vector set table
// Item and result layouts, command codes and fixed field widths.
// ---------------------------------------------------------------------------
package bvst_pkg;

   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;
   localparam int ITEM_W    = 12;
   localparam int COUNT_W   = 13;
   localparam int UNIV_W    = 13;

   localparam logic [UNIV_W-1:0] UNIV_RESET = 13'd4096;

   typedef enum logic [1:0] {
      CMD_LOOKUP = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [ITEM_W-1:0] item;
   } req_type;

   typedef struct packed {
      logic               was_member;
      logic [COUNT_W-1:0] member_count;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic                 was_member;
      logic                 out_of_range;
      logic                 wr_en;
      logic [WORD_BITS-1:0] wr_word;
      logic [COUNT_W-1:0]   count;
   } upd_type;

endpackage

// ----- src/bvst_store.sv -----
// ---------------------------------------------------------------------------
// bvst_store: member word memory
// One write and one registered read per cycle, row valid flags for clearing
// and a bypass for a write that lands on the row being read.
// ---------------------------------------------------------------------------
module bvst_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [bvst_pkg::WORD_BITS-1:0] rd_word,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [bvst_pkg::WORD_BITS-1:0] wr_data
);

   logic [bvst_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [bvst_pkg::WORD_BITS-1:0] mem_q_ff;
   logic [bvst_pkg::WORD_BITS-1:0] byp_word_ff;
   logic [DEPTH-1:0]               row_vld_ff, row_vld_in;
   logic                           row_hit_ff;
   logic                           byp_ff, byp_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      byp_word_ff <= wr_data;
      row_hit_ff  <= row_vld_ff[rd_addr] && !clear;
   end

   always_comb begin
      row_vld_in = row_vld_ff;
      if (clear) begin
         row_vld_in = '0;
      end else if (wr_en) begin
         row_vld_in[wr_addr] = 1'b1;
      end
      byp_in = wr_en && !clear && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         byp_ff     <= 1'b0;
      end else begin
         row_vld_ff <= row_vld_in;
         byp_ff     <= byp_in;
      end
   end

   // a row never written since the last clear reads as empty
   assign rd_word = byp_ff ? byp_word_ff : (row_hit_ff ? mem_q_ff : '0);

endmodule

// ----- src/bvst_update.sv -----
// ---------------------------------------------------------------------------
// bvst_update: command evaluation
// Range check, membership test, word update and running count update.
// ---------------------------------------------------------------------------
module bvst_update #(
   parameter int MAX_ITEMS = 4096
) (
   input  bvst_pkg::req_type                cmd_req,
   input  logic [bvst_pkg::WORD_BITS-1:0]   word,
   input  logic [bvst_pkg::COUNT_W-1:0]     count,
   input  logic [bvst_pkg::UNIV_W-1:0]      universe,
   output bvst_pkg::upd_type                upd
);

   logic                            in_range;
   logic [bvst_pkg::BIT_IDX_W-1:0]  bpos;
   logic                            present;
   logic                            do_add, do_remove;

   always_comb begin
      in_range  = ({1'b0, cmd_req.item} < universe) &&
                  (32'(cmd_req.item) < 32'(MAX_ITEMS));
      bpos      = cmd_req.item[bvst_pkg::BIT_IDX_W-1:0];
      present   = in_range && word[bpos];
      do_add    = in_range && !present && (cmd_req.command == bvst_pkg::CMD_ADD);
      do_remove = present && (cmd_req.command == bvst_pkg::CMD_REMOVE);

      upd.was_member   = present;
      upd.out_of_range = !in_range;
      upd.wr_en        = do_add || do_remove;
      upd.wr_word      = word;
      upd.wr_word[bpos] = do_add;
      upd.count        = count;
      if (do_add) begin
         upd.count = count + 13'd1;
      end else if (do_remove) begin
         upd.count = count - 13'd1;
      end
   end

endmodule

// ----- src/bit_vector_set_table.sv -----
// ---------------------------------------------------------------------------
// bit_vector_set_table: bit vector set with running population count
// Lookup, add and remove of item numbers over a configurable universe.
// ---------------------------------------------------------------------------
//   channel   ports                      direction  handshake
//   request   start, busy, req_data      in         start && !busy
//   response  rsp_strobe, rsp_data       out        one-cycle strobe
//   config    csr_we, csr_wdata          in         csr_we
//
// One item per cycle while busy is low. A result is shown once its item has
// passed the registered word read and then the update and result register.
// A write to the same word by the previous item is bypassed inside the store.
// busy is high for the first cycle after reset, then low; no clearing pass is
// needed since row valid flags clear the store at once. A csr write empties
// the set. The receiver cannot stall.
// ---------------------------------------------------------------------------
module bit_vector_set_table #(
   parameter int MAX_ITEMS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bvst_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output bvst_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [bvst_pkg::UNIV_W-1:0]     csr_wdata
);

   localparam int NUM_WORDS  = (MAX_ITEMS + bvst_pkg::WORD_BITS - 1) / bvst_pkg::WORD_BITS;
   localparam int ITEM_WORDS = (2 ** bvst_pkg::ITEM_W) / bvst_pkg::WORD_BITS;
   localparam int DEPTH      = (NUM_WORDS < ITEM_WORDS) ? NUM_WORDS : ITEM_WORDS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                            accept;
   logic                            busy_ff;
   logic                            stage_vld_ff;
   bvst_pkg::req_type               stage_req_ff;
   logic [bvst_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [bvst_pkg::UNIV_W-1:0]     universe_ff;
   logic                            rsp_strobe_ff;
   bvst_pkg::rsp_type               rsp_ff, rsp_in;
   logic [bvst_pkg::WORD_BITS-1:0]  rd_word;
   logic [ADDR_W-1:0]               rd_addr, wr_addr;
   bvst_pkg::upd_type               upd;

   assign accept  = start && !busy_ff;
   assign rd_addr = ADDR_W'(req_data.item >> bvst_pkg::BIT_IDX_W);
   assign wr_addr = ADDR_W'(stage_req_ff.item >> bvst_pkg::BIT_IDX_W);

   bvst_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_we),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (stage_vld_ff && upd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (upd.wr_word)
   );

   bvst_update #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_update (
      .cmd_req  (stage_req_ff),
      .word     (rd_word),
      .count    (count_ff),
      .universe (universe_ff),
      .upd      (upd)
   );

   always_comb begin
      count_in = count_ff;
      if (csr_we) begin
         count_in = '0;
      end else if (stage_vld_ff && upd.wr_en) begin
         count_in = upd.count;
      end
      rsp_in.was_member   = upd.was_member;
      rsp_in.member_count = upd.count;
      rsp_in.out_of_range = upd.out_of_range;
   end

   always_ff @(posedge clock) begin
      stage_req_ff <= req_data;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         stage_vld_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         count_ff      <= '0;
         universe_ff   <= bvst_pkg::UNIV_RESET;
      end else begin
         busy_ff       <= 1'b0;
         stage_vld_ff  <= accept;
         rsp_strobe_ff <= stage_vld_ff;
         count_ff      <= count_in;
         if (csr_we) begin
            universe_ff <= csr_wdata;
         end
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- src/bvst_checker.sv -----
// ---------------------------------------------------------------------------
// bvst_checker: port-level checks for the bit vector set table
// Result timing and running count behavior seen at the top level ports.
// ---------------------------------------------------------------------------
module bvst_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input bvst_pkg::rsp_type           rsp_data,
   input logic                        csr_we
);

   // every taken item yields a result after the word read and result registers
   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("taken item produced no result");

   // no result without an item taken ahead of it through both registers
   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without a taken item");

   // count moves by at most one between back-to-back results with no csr write
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && !$past(csr_we) && !$past(csr_we, 2)) |->
         ((rsp_data.member_count == $past(rsp_data.member_count)) ||
          (rsp_data.member_count == 13'($past(rsp_data.member_count) + 13'd1)) ||
          (rsp_data.member_count == 13'($past(rsp_data.member_count) - 13'd1))))
      else $error("member count jumped");

   // an out-of-range item leaves the count alone and is never reported a member
   a_oor_holds_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && rsp_data.out_of_range &&
       !$past(csr_we) && !$past(csr_we, 2)) |->
         (!rsp_data.was_member &&
          (rsp_data.member_count == $past(rsp_data.member_count))))
      else $error("out-of-range item changed the set");

endmodule

bind bit_vector_set_table bvst_checker u_bvst_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .csr_we     (csr_we)
);
